// ===== sv/btm_pkg.sv =====
// shared types, constants and helper functions of the bidirectional tape memory
package btm_pkg;

    // store depths and the span of the 13-bit signed head
    localparam int FORWARD_DEPTH = 4096;
    localparam int REVERSE_DEPTH = 4096;
    localparam int HEAD_SPAN     = 4096;

    localparam int HEAD_W   = 13;
    localparam int CELL_W   = 32;
    localparam int AMOUNT_W = 32;
    localparam int LIMIT_W  = 13;
    localparam int CFG_W    = 13;

    localparam int FWD_IDX_W = $clog2(FORWARD_DEPTH);
    localparam int REV_IDX_W = $clog2(REVERSE_DEPTH);

    // highest usable cell count on each side
    localparam int FWD_CAP = (FORWARD_DEPTH < HEAD_SPAN) ? FORWARD_DEPTH : HEAD_SPAN;
    localparam int REV_CAP = (REVERSE_DEPTH < HEAD_SPAN) ? REVERSE_DEPTH : HEAD_SPAN;

    // the clearing sweep covers the deeper store
    localparam int CLEAR_LEN = (FORWARD_DEPTH > REVERSE_DEPTH) ? FORWARD_DEPTH : REVERSE_DEPTH;
    localparam int CLR_W     = $clog2(CLEAR_LEN);

    typedef enum logic [2:0] {
        MODE_SEEK_REL = 3'd0,
        MODE_SEEK_ABS = 3'd1,
        MODE_ADD      = 3'd2,
        MODE_SET      = 3'd3,
        MODE_GET      = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_SEEK     = 2'd1,
        ERR_OVERFLOW = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_32 = 2'd2
    } t_width;

    typedef enum logic [1:0] {
        CFG_CELL_WIDTH    = 2'd0,
        CFG_WRAP_ENABLE   = 2'd1,
        CFG_FORWARD_LIMIT = 2'd2,
        CFG_REVERSE_LIMIT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_READ  = 2'd2,
        S_EXEC  = 2'd3
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic rd_en;
        logic exec;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_dp_sts;

    // sign-extend the low bits of a cell at the given width (code three acts as 32)
    function automatic logic [CELL_W-1:0] sext_cell(logic [CELL_W-1:0] v, logic [1:0] w);
        logic [CELL_W-1:0] r;
        case (w)
            WIDTH_8:  r = {{24{v[7]}}, v[7:0]};
            WIDTH_16: r = {{16{v[15]}}, v[15:0]};
            default:  r = v;
        endcase
        return r;
    endfunction

    // true when a 33-bit signed sum fits the signed range of the width
    function automatic logic sum_fits(logic [CELL_W:0] s, logic [1:0] w);
        logic r;
        case (w)
            WIDTH_8:  r = (&s[CELL_W:7]) | ~(|s[CELL_W:7]);
            WIDTH_16: r = (&s[CELL_W:15]) | ~(|s[CELL_W:15]);
            default:  r = (s[CELL_W] == s[CELL_W-1]);
        endcase
        return r;
    endfunction

endpackage

// ===== sv/btm_ram.sv =====
// generic simple dual-port ram with registered read
module btm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/btm_ctrl.sv =====
// controller state machine of the bidirectional tape memory
module btm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output btm_pkg::t_dp_cmd  o_cmd,
    input  btm_pkg::t_dp_sts  i_sts
);

    btm_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= btm_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            btm_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = btm_pkg::S_IDLE;
                end
            end
            btm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = btm_pkg::S_READ;
                end
            end
            btm_pkg::S_READ: begin
                // read repeats until the result slot is free
                o_cmd.rd_en = 1'b1;
                if (!r_out_valid || i_out_ready) begin
                    n_state = btm_pkg::S_EXEC;
                end
            end
            btm_pkg::S_EXEC: begin
                o_cmd.exec  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = btm_pkg::S_IDLE;
            end
            default: begin
                n_state = btm_pkg::S_CLEAR;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/btm_dpath.sv =====
// datapath of the bidirectional tape memory: config, head, stores and cell arithmetic
module btm_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_index,
    input  logic [btm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [2:0]                    i_mode,
    input  logic [btm_pkg::AMOUNT_W-1:0]  i_amount,
    output logic [btm_pkg::CELL_W-1:0]    o_cell_value,
    output logic [btm_pkg::HEAD_W-1:0]    o_head_position,
    output logic [1:0]                    o_error_code,
    input  btm_pkg::t_dp_cmd              i_cmd,
    output btm_pkg::t_dp_sts              o_sts
);

    // configuration
    logic [1:0]                   r_cell_width;
    logic                         r_wrap_enable;
    logic [btm_pkg::LIMIT_W-1:0]  r_fwd_limit;
    logic [btm_pkg::LIMIT_W-1:0]  r_rev_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width  <= btm_pkg::WIDTH_8;
            r_wrap_enable <= 1'b1;
            r_fwd_limit   <= btm_pkg::LIMIT_W'(4096);
            r_rev_limit   <= btm_pkg::LIMIT_W'(4096);
        end else if (i_cfg_wr_en) begin
            case (btm_pkg::t_cfg_idx'(i_cfg_index))
                btm_pkg::CFG_CELL_WIDTH:    r_cell_width  <= i_cfg_data[1:0];
                btm_pkg::CFG_WRAP_ENABLE:   r_wrap_enable <= i_cfg_data[0];
                btm_pkg::CFG_FORWARD_LIMIT: r_fwd_limit   <= i_cfg_data;
                btm_pkg::CFG_REVERSE_LIMIT: r_rev_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // seek target and bounds
    logic [btm_pkg::HEAD_W-1:0]    r_head;
    logic [btm_pkg::LIMIT_W-1:0]   w_fwd_eff, w_rev_eff;
    logic signed [btm_pkg::AMOUNT_W:0] w_target, w_fwd_bound, w_rev_bound;
    logic                          w_reach;
    logic                          w_is_seek;

    assign w_fwd_eff = (32'(r_fwd_limit) > btm_pkg::FWD_CAP)
                     ? btm_pkg::LIMIT_W'(btm_pkg::FWD_CAP) : r_fwd_limit;
    assign w_rev_eff = (32'(r_rev_limit) > btm_pkg::REV_CAP)
                     ? btm_pkg::LIMIT_W'(btm_pkg::REV_CAP) : r_rev_limit;
    assign w_fwd_bound = $signed({20'b0, w_fwd_eff});
    assign w_rev_bound = -$signed({20'b0, w_rev_eff});

    always_comb begin
        w_is_seek = 1'b0;
        w_target  = $signed({i_amount[btm_pkg::AMOUNT_W-1], i_amount});
        case (btm_pkg::t_mode'(i_mode))
            btm_pkg::MODE_SEEK_REL: begin
                w_is_seek = 1'b1;
                w_target  = $signed({{20{r_head[btm_pkg::HEAD_W-1]}}, r_head})
                          + $signed({i_amount[btm_pkg::AMOUNT_W-1], i_amount});
            end
            btm_pkg::MODE_SEEK_ABS: w_is_seek = 1'b1;
            default: ;
        endcase
        w_reach = w_target[btm_pkg::AMOUNT_W] ? (w_target >= w_rev_bound)
                                                : (w_target < w_fwd_bound);
    end

    // item registers
    btm_pkg::t_mode                r_mode;
    logic [btm_pkg::AMOUNT_W-1:0]  r_amount;
    btm_pkg::t_err                 r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (i_cmd.accept && w_is_seek && w_reach) begin
            r_head <= w_target[btm_pkg::HEAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode   <= btm_pkg::t_mode'(i_mode);
            r_amount <= i_amount;
            r_err    <= (w_is_seek && !w_reach) ? btm_pkg::ERR_SEEK : btm_pkg::ERR_NONE;
        end
    end

    // clearing sweep counter
    logic [btm_pkg::CLR_W-1:0] r_clr_cnt;
    logic [31:0]               w_clr32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign w_clr32          = 32'(r_clr_cnt);
    assign o_sts.clear_last = (w_clr32 == 32'(btm_pkg::CLEAR_LEN - 1));

    // store indexes: position -1 is reverse entry 0
    logic [31:0]                   w_fwd32, w_rev32;
    logic [btm_pkg::FWD_IDX_W-1:0] w_fwd_idx;
    logic [btm_pkg::REV_IDX_W-1:0] w_rev_idx;
    logic                          w_neg;

    assign w_neg     = r_head[btm_pkg::HEAD_W-1];
    assign w_fwd32   = 32'(r_head);
    assign w_rev32   = 32'(~r_head);
    assign w_fwd_idx = w_fwd32[btm_pkg::FWD_IDX_W-1:0];
    assign w_rev_idx = w_rev32[btm_pkg::REV_IDX_W-1:0];

    // cell arithmetic
    logic [btm_pkg::CELL_W-1:0] w_fwd_rd, w_rev_rd, w_cur, w_new;
    logic [btm_pkg::CELL_W:0]   w_sum;
    logic                       w_write;
    btm_pkg::t_err              w_err;

    always_comb begin
        w_cur   = btm_pkg::sext_cell(w_neg ? w_rev_rd : w_fwd_rd, r_cell_width);
        w_sum   = {w_cur[btm_pkg::CELL_W-1], w_cur}
                + {r_amount[btm_pkg::AMOUNT_W-1], r_amount};
        w_new   = w_cur;
        w_write = 1'b0;
        w_err   = r_err;
        case (r_mode)
            btm_pkg::MODE_ADD: begin
                if (!r_wrap_enable && !btm_pkg::sum_fits(w_sum, r_cell_width)) begin
                    w_err = btm_pkg::ERR_OVERFLOW;
                end else begin
                    w_new   = btm_pkg::sext_cell(w_sum[btm_pkg::CELL_W-1:0], r_cell_width);
                    w_write = 1'b1;
                end
            end
            btm_pkg::MODE_SET: begin
                w_new   = btm_pkg::sext_cell(r_amount, r_cell_width);
                w_write = 1'b1;
            end
            default: ;
        endcase
    end

    // store write ports, shared by the sweep and the item write
    logic                          w_fwd_we, w_rev_we;
    logic [btm_pkg::FWD_IDX_W-1:0] w_fwd_waddr;
    logic [btm_pkg::REV_IDX_W-1:0] w_rev_waddr;
    logic [btm_pkg::CELL_W-1:0]    w_wdata;

    assign w_fwd_we    = i_cmd.clear ? (w_clr32 < 32'(btm_pkg::FORWARD_DEPTH))
                                     : (i_cmd.exec && w_write && !w_neg);
    assign w_rev_we    = i_cmd.clear ? (w_clr32 < 32'(btm_pkg::REVERSE_DEPTH))
                                     : (i_cmd.exec && w_write && w_neg);
    assign w_fwd_waddr = i_cmd.clear ? w_clr32[btm_pkg::FWD_IDX_W-1:0] : w_fwd_idx;
    assign w_rev_waddr = i_cmd.clear ? w_clr32[btm_pkg::REV_IDX_W-1:0] : w_rev_idx;
    assign w_wdata     = i_cmd.clear ? '0 : w_new;

    btm_ram #(
        .WIDTH (btm_pkg::CELL_W),
        .DEPTH (btm_pkg::FORWARD_DEPTH)
    ) u_fwd_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_fwd_we),
        .i_wr_addr (w_fwd_waddr),
        .i_wr_data (w_wdata),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_fwd_idx),
        .o_rd_data (w_fwd_rd)
    );

    btm_ram #(
        .WIDTH (btm_pkg::CELL_W),
        .DEPTH (btm_pkg::REVERSE_DEPTH)
    ) u_rev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_rev_we),
        .i_wr_addr (w_rev_waddr),
        .i_wr_data (w_wdata),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rev_idx),
        .o_rd_data (w_rev_rd)
    );

    // result register
    logic [btm_pkg::CELL_W-1:0] r_cell_out;
    logic [btm_pkg::HEAD_W-1:0] r_head_out;
    btm_pkg::t_err              r_err_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_cell_out <= w_new;
            r_head_out <= r_head;
            r_err_out  <= w_err;
        end
    end

    assign o_cell_value    = r_cell_out;
    assign o_head_position = r_head_out;
    assign o_error_code    = r_err_out;

endmodule

// ===== sv/bidirectional_tape_memory_unit.sv =====
// top level of the bidirectional tape memory
//
// data tape with a signed 13-bit head over two stores: positions 0 and up
// live in the forward store, positions -1 and down in the reverse store.
// each input transaction carries a mode (seek relative, seek absolute, add,
// set, get; unused codes act as get) and a 32-bit signed amount, and gives
// exactly one output transaction with the cell under the head sign-extended
// from the current cell width, the head position and an error code. an item
// is accepted in the idle cycle, where the seek is resolved and the head
// moves at the accepting edge; the next cycle does the registered store
// read and the execute state after it the read-modify-write and the
// result load; a new input transaction is taken only once the item before
// it is through execute, so one item is in flight at a time. a finished
// result waits in the output register while the next item is accepted; the
// read cycle of that next item repeats until the waiting result is taken.
// after reset a clearing pass zeroes both stores, one entry of each per
// cycle over the 4096 entries of the deeper store, and no input
// transaction is taken meanwhile; configuration writes are taken at any
// time but should be made while idle.
module bidirectional_tape_memory_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_index,
    input  logic [btm_pkg::CFG_W-1:0]     i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_mode,
    input  logic [btm_pkg::AMOUNT_W-1:0]  i_amount,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [btm_pkg::CELL_W-1:0]    o_cell_value,
    output logic [btm_pkg::HEAD_W-1:0]    o_head_position,
    output logic [1:0]                    o_error_code
);

    btm_pkg::t_dp_cmd w_cmd;
    btm_pkg::t_dp_sts w_sts;

    // sequencing: clear sweep, accept, read, execute
    btm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // head, stores, cell arithmetic and result register
    btm_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_amount        (i_amount),
        .o_cell_value    (o_cell_value),
        .o_head_position (o_head_position),
        .o_error_code    (o_error_code),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts)
    );

endmodule

// ===== tb/tb_bidirectional_tape_memory_unit.sv =====
// testbench for the bidirectional tape memory unit: random tape programs checked against a predictor
`timescale 1ns / 100ps

module tb_bidirectional_tape_memory_unit;

    // codes with no name in the package
    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;
    localparam logic [1:0] WIDTH_32_ALT      = 2'd3;

    // cycles with no transaction on either side before the run is abandoned;
    // covers the clearing pass after reset with plenty of margin
    localparam int STALL_LIMIT  = 20000;
    // cycles to let pass once the last result is in
    localparam int SETTLE       = 8;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] amount;
    } t_tape_op;

    typedef struct packed {
        logic [31:0] cell_value;
        logic [12:0] head;
        logic [1:0]  err;
    } t_tape_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_mode = '0;
    logic [31:0] i_amount = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_cell_value;
    logic [12:0] o_head_position;
    logic [1:0]  o_error_code;

    bidirectional_tape_memory_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_amount        (i_amount),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cell_value    (o_cell_value),
        .o_head_position (o_head_position),
        .o_error_code    (o_error_code)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the tape and its registers
    logic [1:0]  tape_width;
    logic        tape_wrap;
    logic [12:0] tape_fwd_limit;
    logic [12:0] tape_rev_limit;
    int          tape_head;
    logic [31:0] fwd_cells [btm_pkg::FORWARD_DEPTH];
    logic [31:0] rev_cells [btm_pkg::REVERSE_DEPTH];

    t_tape_op     pending_ops[$];    // operations not yet handed to the driver
    t_tape_answer tape_answers[$];   // predicted results in arrival order
    t_tape_op     cur_op;
    logic         sending = 1'b0;    // mirror of i_in_valid
    int           send_idle;         // percent of cycles the sender holds back
    int           recv_idle;         // percent of cycles the receiver stalls
    int           mismatch_count = 0;
    int           quiet_cycles = 0;

    // keep the low bits of the current width and sign-extend them;
    // shift is 24 for 8-bit cells, 16 for 16-bit, 0 for 32-bit
    function automatic logic [31:0] narrow_to_cell(logic [31:0] v, int shift);
        logic signed [31:0] t;
        t = v << shift;
        return t >>> shift;
    endfunction

    function automatic int width_shift();
        return (tape_width == btm_pkg::WIDTH_8) ? 24 :
               (tape_width == btm_pkg::WIDTH_16) ? 16 : 0;
    endfunction

    // apply one operation to the predictor tape and return the expected result
    function automatic t_tape_answer predict_tape_op(t_tape_op op);
        longint       amt, target, cur, sum, hi, lo, fcap, rcap;
        int           sh;
        logic [31:0]  tape_word;
        logic [1:0]   err;
        t_tape_answer ans;
        amt = longint'($signed(op.amount));
        sh  = width_shift();
        err = btm_pkg::ERR_NONE;
        // seeks first: both kinds share one bounds test, head stays on error
        if (op.mode == btm_pkg::MODE_SEEK_REL || op.mode == btm_pkg::MODE_SEEK_ABS) begin
            target = (op.mode == btm_pkg::MODE_SEEK_REL) ? longint'(tape_head) + amt : amt;
            fcap = (tape_fwd_limit < btm_pkg::FWD_CAP) ? tape_fwd_limit : btm_pkg::FWD_CAP;
            rcap = (tape_rev_limit < btm_pkg::REV_CAP) ? tape_rev_limit : btm_pkg::REV_CAP;
            if ((target >= 0) ? (target < fcap) : (target >= -rcap))
                tape_head = int'(target);
            else
                err = btm_pkg::ERR_SEEK;
        end
        // position -1 is reverse entry 0
        tape_word = (tape_head >= 0) ? fwd_cells[tape_head] : rev_cells[-tape_head - 1];
        if (op.mode == btm_pkg::MODE_ADD) begin
            cur = longint'($signed(narrow_to_cell(tape_word, sh)));
            sum = cur + amt;
            hi  = (longint'(1) << (31 - sh)) - 1;
            lo  = -hi - 1;
            if (!tape_wrap && (sum > hi || sum < lo))
                err = btm_pkg::ERR_OVERFLOW;
            else
                tape_word = narrow_to_cell(sum[31:0], sh);
        end else if (op.mode == btm_pkg::MODE_SET) begin
            tape_word = narrow_to_cell(op.amount, sh);
        end
        if (op.mode == btm_pkg::MODE_ADD || op.mode == btm_pkg::MODE_SET) begin
            if (tape_head >= 0)
                fwd_cells[tape_head] = tape_word;
            else
                rev_cells[-tape_head - 1] = tape_word;
        end
        ans.cell_value = narrow_to_cell(tape_word, sh);
        ans.head       = tape_head[12:0];
        ans.err        = err;
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch on %0s at %0t: got %h, expected %h", what, $time, got, want);
    endtask

    // driver: one operation in flight on the input channel, prediction at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sending = 1'b0;
            i_in_valid <= 1'b0;
        end else begin
            if (sending && o_in_ready) begin
                tape_answers.push_back(predict_tape_op(cur_op));
                sending = 1'b0;
            end
            // valid is raised independently of ready and held until the transaction
            if (!sending && pending_ops.size() > 0 && $urandom_range(99) >= send_idle) begin
                cur_op = pending_ops.pop_front();
                sending = 1'b1;
                i_mode   <= cur_op.mode;
                i_amount <= cur_op.amount;
            end
            i_in_valid <= sending;
        end
    end

    // monitor: compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_tape_answer want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (tape_answers.size() == 0) begin
                    report_mismatch("unexpected transaction", o_cell_value, '0);
                end else begin
                    want = tape_answers.pop_front();
                    if (o_cell_value !== want.cell_value)
                        report_mismatch("cell_value", o_cell_value, want.cell_value);
                    if (o_head_position !== want.head)
                        report_mismatch("head_position", 32'(o_head_position), 32'(want.head));
                    if (o_error_code !== want.err)
                        report_mismatch("error_code", 32'(o_error_code), 32'(want.err));
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog: abandon the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("[bidirectional_tape_memory_unit] ERROR");
                $finish;
            end
        end
    end

    // register write; the predictor copy follows at once since the block is idle
    task automatic write_reg(btm_pkg::t_cfg_idx idx, logic [12:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            btm_pkg::CFG_CELL_WIDTH:    tape_width = value[1:0];
            btm_pkg::CFG_WRAP_ENABLE:   tape_wrap = value[0];
            btm_pkg::CFG_FORWARD_LIMIT: tape_fwd_limit = value;
            btm_pkg::CFG_REVERSE_LIMIT: tape_rev_limit = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_tape_mode(logic [1:0] width, logic wrap, logic [12:0] fwd,
                                 logic [12:0] rev);
        write_reg(btm_pkg::CFG_CELL_WIDTH, 13'(width));
        write_reg(btm_pkg::CFG_WRAP_ENABLE, 13'(wrap));
        write_reg(btm_pkg::CFG_FORWARD_LIMIT, fwd);
        write_reg(btm_pkg::CFG_REVERSE_LIMIT, rev);
    endtask

    task automatic push_op(logic [2:0] mode, logic [31:0] amount);
        t_tape_op op;
        op.mode   = mode;
        op.amount = amount;
        pending_ops.push_back(op);
    endtask

    // sender holds off until every predicted result is in, then a short settle
    task automatic drain_tape();
        while (pending_ops.size() != 0 || sending || tape_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // tape programs: mostly short head moves and arithmetic on nearby cells,
    // with bound probes, full-range values and the unused mode codes mixed in
    function automatic t_tape_op random_op();
        t_tape_op op;
        int       pick, fcap, rcap;
        fcap = (tape_fwd_limit < btm_pkg::FWD_CAP) ? tape_fwd_limit : btm_pkg::FWD_CAP;
        rcap = (tape_rev_limit < btm_pkg::REV_CAP) ? tape_rev_limit : btm_pkg::REV_CAP;
        pick = $urandom_range(99);
        op.amount = $urandom;
        if (pick < 26) begin
            op.mode = btm_pkg::MODE_SEEK_REL;
            if ($urandom_range(19) != 0)
                op.amount = int'($urandom_range(12)) - 6;
        end else if (pick < 34) begin
            op.mode = btm_pkg::MODE_SEEK_ABS;
            case ($urandom_range(5))
                0: op.amount = fcap - 1;
                1: op.amount = fcap;
                2: op.amount = -rcap;
                3: op.amount = -rcap - 1;
                4: op.amount = int'($urandom_range(fcap + rcap - 1)) - rcap;
                default: ;
            endcase
        end else if (pick < 60) begin
            op.mode = btm_pkg::MODE_ADD;
            case ($urandom_range(3))
                0, 1: op.amount = int'($urandom_range(80)) - 40;
                2:    op.amount = narrow_to_cell($urandom, width_shift());
                default: ;
            endcase
        end else if (pick < 80) begin
            op.mode = btm_pkg::MODE_SET;
            if ($urandom_range(3) == 0)
                op.amount = int'($urandom_range(40)) - 20;
        end else if (pick < 95) begin
            op.mode = btm_pkg::MODE_GET;
        end else begin
            op.mode = 3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
        end
        return op;
    endfunction

    task automatic run_random(int count);
        repeat (count) pending_ops.push_back(random_op());
        drain_tape();
    endtask

    initial begin
        // predictor starts from the reset state
        tape_width     = btm_pkg::WIDTH_8;
        tape_wrap      = 1'b1;
        tape_fwd_limit = 13'd4096;
        tape_rev_limit = 13'd4096;
        tape_head      = 0;
        foreach (fwd_cells[i]) fwd_cells[i] = '0;
        foreach (rev_cells[i]) rev_cells[i] = '0;
        send_idle = 34;
        recv_idle = 86;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 8-bit cells, wrap on, full limits (reset values)
        push_op(btm_pkg::MODE_GET, 32'd0);
        push_op(btm_pkg::MODE_SET, 32'd127);
        push_op(btm_pkg::MODE_ADD, 32'd1);              // wraps to -128
        push_op(btm_pkg::MODE_ADD, 32'hFFFF_FFFF);      // wraps back to 127
        push_op(btm_pkg::MODE_SET, 32'h1234_5680);      // truncated to the width
        push_op(btm_pkg::MODE_SEEK_REL, 32'hFFFF_FFFF); // first reverse cell
        push_op(btm_pkg::MODE_SET, 32'h0000_0155);
        push_op(btm_pkg::MODE_SEEK_ABS, 32'd4095);      // last forward cell
        push_op(btm_pkg::MODE_SET, 32'd1);
        push_op(btm_pkg::MODE_SEEK_ABS, 32'd4096);      // one past the forward end
        push_op(btm_pkg::MODE_SEEK_ABS, -32'sd4096);    // last reverse cell
        push_op(btm_pkg::MODE_SEEK_ABS, -32'sd4097);    // one past the reverse end
        push_op(btm_pkg::MODE_SEEK_REL, 32'd1);
        push_op(btm_pkg::MODE_SEEK_REL, 32'h7FFF_FFFF); // extreme distances
        push_op(btm_pkg::MODE_SEEK_REL, 32'h8000_0000);
        push_op(btm_pkg::MODE_SEEK_ABS, 32'hFFFF_FFFF);
        push_op(MODE_UNUSED_FIRST, 32'hFFFF_FFFF);
        push_op(MODE_UNUSED_LAST, 32'h8000_0000);
        drain_tape();

        // 32-bit cells, no wrap: overflow at the full width
        set_tape_mode(btm_pkg::WIDTH_32, 1'b0, 13'd4096, 13'd4096);
        push_op(btm_pkg::MODE_SET, 32'h1234_5681);
        push_op(btm_pkg::MODE_ADD, 32'h7FFF_FFFF);      // positive overflow
        push_op(btm_pkg::MODE_ADD, 32'h8000_0000);      // large negative that still fits
        drain_tape();

        // back to 8-bit: reverse cell read through the narrower width
        set_tape_mode(btm_pkg::WIDTH_8, 1'b0, 13'd4096, 13'd4096);
        push_op(btm_pkg::MODE_GET, 32'd0);
        push_op(btm_pkg::MODE_SET, 32'd127);
        push_op(btm_pkg::MODE_ADD, 32'd1);              // overflow, cell kept
        push_op(btm_pkg::MODE_ADD, -32'sd255);          // lands on -128 exactly
        push_op(btm_pkg::MODE_ADD, 32'hFFFF_FFFF);      // negative overflow
        push_op(btm_pkg::MODE_ADD, 32'h8000_0000);
        drain_tape();

        // random phases; limits lowered below the head leave it in place
        set_tape_mode(btm_pkg::WIDTH_8, 1'b1, 13'd4096, 13'd4096);
        run_random(300);
        set_tape_mode(btm_pkg::WIDTH_16, 1'b0, 13'd16, 13'd0);
        run_random(300);

        send_idle = 86;
        recv_idle = 34;
        set_tape_mode(btm_pkg::WIDTH_32, 1'b0, 13'd1, 13'd4096);
        run_random(300);
        set_tape_mode(WIDTH_32_ALT, 1'b1, 13'd8191, 13'd8191);
        run_random(300);

        send_idle = 0;
        recv_idle = 0;
        set_tape_mode(btm_pkg::WIDTH_8, 1'b0, 13'd100, 13'd37);
        run_random(300);
        set_tape_mode(btm_pkg::WIDTH_16, 1'b1, 13'd4096, 13'd1);
        run_random(300);

        if (mismatch_count == 0 && tape_answers.size() == 0) begin
            $display("[bidirectional_tape_memory_unit] OK");
        end else begin
            $display("[bidirectional_tape_memory_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/btm_pkg.sv
sv/btm_ram.sv
sv/btm_ctrl.sv
sv/btm_dpath.sv
sv/bidirectional_tape_memory_unit.sv
tb/tb_bidirectional_tape_memory_unit.sv
